FILE: design/assert_macros.svh
// Assertion macros shared by the address region table modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on the rising clock edge, disabled while reset is low.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Two signals of one group are never active in the same cycle.
`define ASSERT_EXCL(label, clk, rst_n, a, b, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !((a) && (b))) else $error(msg);

`endif

FILE: design/art_pkg.sv
// Shared constants, codes and controller command type for the address region table.
package art_pkg;

  localparam int TABLE_ENTRIES_DEF = 2048;
  localparam int ADDR_BITS_DEF = 64;
  localparam int FIELD_ADDR_W = 64;
  localparam int USED_W = 12;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_PUNCH = 2'd1;
  localparam logic [1:0] OP_UNMAP = 2'd2;
  localparam logic [1:0] OP_LOOKUP = 2'd3;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_OVERLAP = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  typedef struct packed {
    logic load;
    logic clr;
    logic rd;
    logic commit;
    logic res_load;
  } ctl_cmd_t;

endpackage

FILE: design/address_region_table.sv
// Top level of the address region table: controller and datapath.
// Usage:
// The input channel (in_valid/in_ready) carries one command word: in_opcode
// selects insert, punch or unmap on the range in_range_start to in_range_end,
// inclusive, or a lookup of the address in_range_start. The result channel (out_valid/out_ready) returns one
// word per command with out_hit, out_status and out_used_count.
// Every command scans all TABLE_ENTRIES slots, one per cycle through the
// read port of the region memories, then evaluates the last slot in S_LAST
// and commits the final store and status in S_COMMIT; S_DONE loads the result.
// One command is in work at a time: in_ready is high only in S_IDLE, so
// no new command is accepted until the current one has reached the output
// register.
// After reset the block runs a clearing pass over the valid bits of all
// TABLE_ENTRIES slots, with in_ready low, before it accepts the first word.
// A finished result sits in an output register; the next command is accepted
// and scanned while it waits. If the receiver still stalls when that next
// result is ready, the block holds it and accepts nothing further.
module address_region_table #(
  parameter int TABLE_ENTRIES = art_pkg::TABLE_ENTRIES_DEF,
  parameter int ADDR_BITS = art_pkg::ADDR_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_opcode,
  input  logic [art_pkg::FIELD_ADDR_W-1:0] in_range_start,
  input  logic [art_pkg::FIELD_ADDR_W-1:0] in_range_end,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_hit,
  output logic [1:0]  out_status,
  output logic [art_pkg::USED_W-1:0] out_used_count
);

  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

  art_pkg::ctl_cmd_t cmd;
  logic [IDX_W-1:0]  idx;

  art_ctrl #(
    .N(TABLE_ENTRIES),
    .IDX_W(IDX_W)
  ) u_ctrl (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .cmd(cmd),
    .idx(idx)
  );

  art_datapath #(
    .N(TABLE_ENTRIES),
    .AW(ADDR_BITS),
    .IDX_W(IDX_W),
    .CNT_W(CNT_W)
  ) u_dp (
    .clk(clk),
    .rst_n(rst_n),
    .cmd(cmd),
    .idx(idx),
    .in_opcode(in_opcode),
    .in_start(in_range_start[ADDR_BITS-1:0]),
    .in_end(in_range_end[ADDR_BITS-1:0]),
    .out_hit(out_hit),
    .out_status(out_status),
    .out_used(out_used_count)
  );

endmodule

FILE: design/art_datapath.sv
// Datapath: region memories, per-entry scan evaluation, counters and result registers.
`include "assert_macros.svh"
module art_datapath #(
  parameter int N = art_pkg::TABLE_ENTRIES_DEF,
  parameter int AW = art_pkg::ADDR_BITS_DEF,
  parameter int IDX_W = 11,
  parameter int CNT_W = 12
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  art_pkg::ctl_cmd_t       cmd,
  input  logic [IDX_W-1:0]        idx,
  input  logic [1:0]              in_opcode,
  input  logic [AW-1:0]           in_start,
  input  logic [AW-1:0]           in_end,
  output logic                    out_hit,
  output logic [1:0]              out_status,
  output logic [art_pkg::USED_W-1:0] out_used
);

  logic [AW-1:0] start_mem [N];
  logic [AW-1:0] end_mem [N];
  logic          valid_mem [N];

  logic [AW-1:0] rs_q, re_q;
  logic          rv_q;

  logic [1:0]       op_r;
  logic [AW-1:0]    s_r, e_r, rem_s_r, rem_e_r;
  logic             proc_vld_r;
  logic [IDX_W-1:0] proc_idx_r, free_idx_r;
  logic             ov_any_r, rem_pend_r, free_fnd_r, hit_r;
  logic [1:0]       status_r;
  logic [CNT_W-1:0] used_r, used_nxt;
  logic             out_hit_r;
  logic [1:0]       out_status_r;
  logic [art_pkg::USED_W-1:0] out_used_r;

  logic          skip, ov, cut, left, right, cand, ins_ok, rem_ok;
  logic [AW-1:0] e_cmp;
  logic          we_se, we_v, wv;
  logic [IDX_W-1:0] wa;
  logic [AW-1:0] ws, wen;
  logic [1:0]    status_nxt;

  always_comb begin
    skip = (op_r != art_pkg::OP_LOOKUP) && (s_r > e_r);
    e_cmp = (op_r == art_pkg::OP_LOOKUP) ? s_r : e_r;
    ov = proc_vld_r && rv_q && !skip && (rs_q <= e_cmp) && (s_r <= re_q);
    cut = ov && ((op_r == art_pkg::OP_PUNCH) || (op_r == art_pkg::OP_UNMAP));
    left = cut && (op_r == art_pkg::OP_PUNCH) && (rs_q < s_r);
    right = cut && (op_r == art_pkg::OP_PUNCH) && (re_q > e_r);
    cand = proc_vld_r && (!rv_q || (cut && !left && !rem_pend_r));
    ins_ok = (op_r == art_pkg::OP_INSERT) && !skip && !ov_any_r && free_fnd_r;
    rem_ok = (op_r == art_pkg::OP_PUNCH) && rem_pend_r && free_fnd_r;
    if ((op_r == art_pkg::OP_INSERT) && !skip) begin
      status_nxt = ov_any_r ? art_pkg::ST_OVERLAP :
                   (free_fnd_r ? art_pkg::ST_OK : art_pkg::ST_FULL);
    end else if ((op_r == art_pkg::OP_PUNCH) && rem_pend_r && !free_fnd_r) begin
      status_nxt = art_pkg::ST_FULL;
    end else begin
      status_nxt = art_pkg::ST_OK;
    end
  end

  always_comb begin
    we_se = 1'b0;
    we_v = 1'b0;
    wv = 1'b0;
    wa = idx;
    ws = s_r;
    wen = e_r;
    used_nxt = used_r;
    priority if (cmd.clr) begin
      we_v = 1'b1;
    end else if (cut) begin
      wa = proc_idx_r;
      if (left) begin
        we_se = 1'b1;
        ws = rs_q;
        wen = s_r - 1'b1;
      end else begin
        we_v = 1'b1;
        used_nxt = used_r - 1'b1;
      end
    end else if (cmd.commit && (ins_ok || rem_ok)) begin
      wa = free_idx_r;
      we_se = 1'b1;
      we_v = 1'b1;
      wv = 1'b1;
      ws = ins_ok ? s_r : rem_s_r;
      wen = ins_ok ? e_r : rem_e_r;
      used_nxt = used_r + 1'b1;
    end else begin
      used_nxt = used_r;
    end
  end

  always_ff @(posedge clk) begin
    if (we_se) begin
      start_mem[wa] <= ws;
      end_mem[wa] <= wen;
    end
    if (we_v) begin
      valid_mem[wa] <= wv;
    end
    if (cmd.rd) begin
      rs_q <= start_mem[idx];
      re_q <= end_mem[idx];
      rv_q <= valid_mem[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      proc_vld_r <= 1'b0;
      used_r <= '0;
      ov_any_r <= 1'b0;
      rem_pend_r <= 1'b0;
      free_fnd_r <= 1'b0;
    end else begin
      proc_vld_r <= cmd.rd;
      used_r <= used_nxt;
      if (cmd.load) begin
        ov_any_r <= 1'b0;
        rem_pend_r <= 1'b0;
        free_fnd_r <= 1'b0;
      end else begin
        if (ov) begin
          ov_any_r <= 1'b1;
        end
        if (right) begin
          rem_pend_r <= 1'b1;
        end
        if (cand && !free_fnd_r) begin
          free_fnd_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    proc_idx_r <= idx;
    if (cmd.load) begin
      op_r <= in_opcode;
      s_r <= in_start;
      e_r <= in_end;
    end
    if (cand && !free_fnd_r) begin
      free_idx_r <= proc_idx_r;
    end
    if (right) begin
      rem_s_r <= e_r + 1'b1;
      rem_e_r <= re_q;
    end
    if (cmd.commit) begin
      status_r <= status_nxt;
      hit_r <= (op_r == art_pkg::OP_LOOKUP) && ov_any_r;
    end
    if (cmd.res_load) begin
      out_hit_r <= hit_r;
      out_status_r <= status_r;
      out_used_r <= art_pkg::USED_W'(used_r);
    end
  end

  assign out_hit = out_hit_r;
  assign out_status = out_status_r;
  assign out_used = out_used_r;

  `ASSERT_CLK(a_used_bound, clk, rst_n, used_r <= CNT_W'(N),
    "Valid range count exceeds the table size.")
  `ASSERT_EXCL(a_single_remnant, clk, rst_n, right, rem_pend_r,
    "A second right remnant appeared within one punch.")

endmodule

FILE: design/art_ctrl.sv
// Controller: clearing pass, table scan sequencing and handshake control.
`include "assert_macros.svh"
module art_ctrl #(
  parameter int N = art_pkg::TABLE_ENTRIES_DEF,
  parameter int IDX_W = 11
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output art_pkg::ctl_cmd_t cmd,
  output logic [IDX_W-1:0]  idx
);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_SCAN, S_LAST, S_COMMIT, S_DONE
  } state_t;

  state_t           state_r;
  logic [IDX_W-1:0] idx_r;
  logic             out_valid_r;
  logic             idx_last, accept, out_free;

  assign idx_last = (idx_r == IDX_W'(N - 1));
  assign in_ready = (state_r == S_IDLE);
  assign accept = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    cmd = '0;
    cmd.load = accept;
    cmd.clr = (state_r == S_CLEAR);
    cmd.rd = (state_r == S_SCAN);
    cmd.commit = (state_r == S_COMMIT);
    cmd.res_load = (state_r == S_DONE) && out_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      idx_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if ((state_r == S_DONE) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_CLEAR: begin
          if (idx_last) begin
            idx_r <= '0;
            state_r <= S_IDLE;
          end else begin
            idx_r <= idx_r + 1'b1;
          end
        end
        S_IDLE: begin
          if (accept) begin
            idx_r <= '0;
            state_r <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (idx_last) begin
            idx_r <= '0;
            state_r <= S_LAST;
          end else begin
            idx_r <= idx_r + 1'b1;
          end
        end
        S_LAST: begin
          state_r <= S_COMMIT;
        end
        S_COMMIT: begin
          state_r <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign idx = idx_r;

  `ASSERT_CLK(a_accept_starts_scan, clk, rst_n, accept |=> (state_r == S_SCAN),
    "An accepted word did not start a table scan.")
  `ASSERT_CLK(a_scan_ends_in_commit, clk, rst_n, (state_r == S_LAST) |=> cmd.commit,
    "The scan did not finish with a commit.")
  `ASSERT_EXCL(a_no_load_while_busy, clk, rst_n, cmd.load, cmd.rd || cmd.clr,
    "A word was accepted during a scan or clearing pass.")

endmodule
